>>> sv/saa_pkg.sv
`default_nettype none
package saa_pkg;

    localparam int ATLAS_COLUMNS_DEF = 64;
    localparam int CELL_PX_DEF       = 32;
    localparam int MAX_ENTRIES_DEF   = 1024;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_KEEP  = 3'd4;

    localparam logic ACT_ALLOC    = 1'b0;
    localparam logic ACT_TRUNCATE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [11:0] width_px;
        logic [11:0] height_px;
        logic [10:0] keep_count;
    } saa_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  handle;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [11:0] offset_x_px;
        logic [11:0] offset_y_px;
    } saa_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture item, compute cell sizes
        logic scan_init;  // clear search state, column pointer to 0
        logic scan_step;  // examine one column
        logic commit;     // write record, set up raise
        logic raise_step; // raise one column
        logic clear_step; // clear one skyline column
        logic fetch;      // record read wait; the datapath reads the record store without it
        logic replay_set; // set up raise from record
        logic set_count;  // count to keep value
        logic finish;     // build result
    } saa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_trunc;
        logic full;
        logic too_large;
        logic bad_keep;
        logic keep_same;
        logic scan_done;
        logic found;
        logic raise_done;
        logic clear_done;
        logic replay_done;
    } saa_sts_t;

endpackage
`default_nettype wire

>>> sv/skyline_atlas_allocator_core.sv
`default_nettype none
// allocate: time set by the one-column-per-cycle skyline scan over every window position,
//   followed by the raise of the placed columns
// truncate: a skyline clearing pass, then a raise for each kept record replayed from the record store
// one item at a time; result waits in an output register until taken
// reset: count zero, border zero, then a skyline clearing pass over every column
//   before the first item is taken; record store not cleared
module skyline_atlas_allocator_core #(
    parameter int ATLAS_COLUMNS = saa_pkg::ATLAS_COLUMNS_DEF,
    parameter int CELL_PX       = saa_pkg::CELL_PX_DEF,
    parameter int MAX_ENTRIES   = saa_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire saa_pkg::saa_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output saa_pkg::saa_out_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [3:0]        cfg_data
);
    import saa_pkg::*;

    saa_in_t    item_reg;
    logic [3:0] border_reg;
    saa_cmd_t   cmd;
    saa_sts_t   sts;
    logic [2:0] err_status;
    logic       err_valid, busy, in_fire;

    assign in_ready  = !busy;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // item capture and border register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg <= '0;
        end
        else if (cfg_valid)
        begin
            border_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
    end

    saa_ctrl u_ctrl (
        .clk, .rst_n, .in_fire, .out_ready, .sts, .cmd,
        .err_status, .err_valid, .busy, .out_valid
    );

    saa_datapath #(
        .ATLAS_COLUMNS(ATLAS_COLUMNS), .CELL_PX(CELL_PX), .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dp (
        .clk, .rst_n,
        .item(in_fire ? in_data : item_reg),
        .border_px(border_reg),
        .cmd, .err_status, .err_valid, .sts,
        .result(out_data)
    );

endmodule
`default_nettype wire

>>> sv/saa_datapath.sv
`default_nettype none
module saa_datapath #(
    parameter int ATLAS_COLUMNS = saa_pkg::ATLAS_COLUMNS_DEF,
    parameter int CELL_PX       = saa_pkg::CELL_PX_DEF,
    parameter int MAX_ENTRIES   = saa_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire saa_pkg::saa_in_t item,
    input  wire logic [3:0]      border_px,
    input  wire saa_pkg::saa_cmd_t cmd,
    input  wire logic [2:0]      err_status,
    input  wire logic            err_valid,
    output saa_pkg::saa_sts_t    sts,
    output saa_pkg::saa_out_t    result
);
    import saa_pkg::*;

    localparam int CW = $clog2(ATLAS_COLUMNS + 1);   // cell count width
    localparam int XW = $clog2(ATLAS_COLUMNS);        // column index width
    localparam int NW = $clog2(MAX_ENTRIES + 1);      // record count width
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SW = 14;                            // padded size width
    localparam int RW = 4 * CW;

    // skyline store, one registered read and one write per cycle
    logic [CW-1:0] sky_mem [ATLAS_COLUMNS];
    logic [CW-1:0] sky_rd_reg;
    logic [RW-1:0] rec_mem [MAX_ENTRIES];
    logic [RW-1:0] rec_rd_reg;

    logic [NW-1:0] count_reg;
    logic [CW-1:0] gw_reg, gh_reg, sw_reg;
    logic [CW:0]   cx_reg;          // window start
    logic [CW:0]   ptr_reg;         // column walk pointer
    logic [CW:0]   ptr_next;
    logic [CW-1:0] top_reg;         // running max in current window
    logic [CW-1:0] best_y_reg;
    logic [XW-1:0] best_x_reg;
    logic          found_reg;
    logic [CW:0]   rx_reg, rend_reg;
    logic [CW-1:0] rtop_reg;
    logic [NW-1:0] ri_reg;
    logic [CW:0]   clr_reg;
    logic          big_reg;
    saa_out_t      result_reg;
    saa_out_t      result_next;

    // padded size to cells, ceiling divide by constant
    logic [SW-1:0] pw, ph, cw_full, ch_full;
    always_comb
    begin
        pw = SW'(item.width_px) + SW'({border_px, 1'b0}) + SW'(CELL_PX - 1);
        ph = SW'(item.height_px) + SW'({border_px, 1'b0}) + SW'(CELL_PX - 1);
        cw_full = pw / SW'(CELL_PX);
        ch_full = ph / SW'(CELL_PX);
    end

    // window walk: ptr runs cx .. cx+sw-1, column height registered from ptr_next so it lines up with ptr
    logic [CW-1:0] col_h, top_new;
    logic          win_last;
    logic [CW+1:0] fit_sum;
    always_comb
    begin
        col_h    = sky_rd_reg;
        top_new  = (col_h > top_reg) ? col_h : top_reg;
        win_last = ((ptr_reg + 1'b1) == (cx_reg + (CW+1)'(sw_reg)));
        fit_sum  = (CW+2)'(top_new) + (CW+2)'(gh_reg);
        if (cmd.scan_init)
        begin
            ptr_next = '0;
        end
        else if (cmd.scan_step)
        begin
            ptr_next = win_last ? (cx_reg + 1'b1) : (ptr_reg + 1'b1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                clr_reg <= '0;
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.set_count)
            begin
                count_reg <= item.keep_count[NW-1:0];
            end
        end
    end

    // skyline store
    always_ff @(posedge clk)
    begin
        if (cmd.raise_step && rx_reg < rend_reg && rx_reg < (CW+1)'(ATLAS_COLUMNS))
        begin
            sky_mem[rx_reg[XW-1:0]] <= rtop_reg;
        end
        if (cmd.clear_step)
        begin
            sky_mem[clr_reg[XW-1:0]] <= '0;
        end
        sky_rd_reg <= sky_mem[ptr_next[XW-1:0]];
    end

    // record store
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rec_mem[count_reg[AW-1:0]] <= {CW'(best_x_reg), best_y_reg, gw_reg, gh_reg};
        end
        rec_rd_reg <= rec_mem[ri_reg[AW-1:0]];
    end

    // result fields
    always_comb
    begin
        result_next = '0;
        if (err_valid)
        begin
            result_next.status = err_status;
        end
        else if (!item.action)
        begin
            result_next.status      = ST_OK;
            result_next.handle      = 10'(count_reg - 1'b1);
            result_next.cell_x      = 6'(best_x_reg);
            result_next.cell_y      = 6'(best_y_reg);
            result_next.offset_x_px = 12'(best_x_reg * CELL_PX) + 12'(border_px);
            result_next.offset_y_px = 12'(best_y_reg * CELL_PX) + 12'(border_px);
        end
        else
        begin
            result_next.status = ST_OK;
        end
    end

    // search, raise and replay datapath
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            big_reg <= (cw_full > SW'(ATLAS_COLUMNS)) || (ch_full > SW'(ATLAS_COLUMNS));
            gw_reg  <= cw_full[CW-1:0];
            gh_reg  <= ch_full[CW-1:0];
            sw_reg  <= (cw_full == '0) ? CW'(1) : cw_full[CW-1:0];
            ri_reg  <= '0;
        end
        if (cmd.scan_init)
        begin
            cx_reg    <= '0;
            ptr_reg   <= '0;
            top_reg   <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            if (win_last)
            begin
                if (fit_sum <= (CW+2)'(ATLAS_COLUMNS) && (!found_reg || top_new < best_y_reg))
                begin
                    found_reg  <= 1'b1;
                    best_x_reg <= cx_reg[XW-1:0];
                    best_y_reg <= top_new;
                end
                cx_reg  <= cx_reg + 1'b1;
                ptr_reg <= cx_reg + 1'b1;
                top_reg <= '0;
            end
            else
            begin
                ptr_reg <= ptr_reg + 1'b1;
                top_reg <= top_new;
            end
        end
        if (cmd.commit)
        begin
            rx_reg   <= (CW+1)'(best_x_reg);
            rend_reg <= (CW+1)'(best_x_reg) + (CW+1)'(gw_reg);
            rtop_reg <= best_y_reg + gh_reg;
        end
        if (cmd.replay_set)
        begin
            rx_reg   <= (CW+1)'(rec_rd_reg[RW-1 -: CW]);
            rend_reg <= (CW+1)'(rec_rd_reg[RW-1 -: CW]) + (CW+1)'(rec_rd_reg[2*CW-1 -: CW]);
            rtop_reg <= rec_rd_reg[3*CW-1 -: CW] + rec_rd_reg[CW-1:0];
            ri_reg   <= ri_reg + 1'b1;
        end
        if (cmd.raise_step)
        begin
            rx_reg <= rx_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    // status to controller
    always_comb
    begin
        sts.is_trunc    = item.action;
        sts.full        = (count_reg >= NW'(MAX_ENTRIES));
        sts.too_large   = big_reg;
        sts.bad_keep    = ({1'b0, item.keep_count} > 12'(count_reg));
        sts.keep_same   = ({1'b0, item.keep_count} == 12'(count_reg));
        sts.scan_done   = (cx_reg + (CW+1)'(sw_reg)) > (CW+1)'(ATLAS_COLUMNS);
        sts.found       = found_reg;
        sts.raise_done  = (rx_reg >= rend_reg) || (rx_reg >= (CW+1)'(ATLAS_COLUMNS));
        sts.clear_done  = (clr_reg == (CW+1)'(ATLAS_COLUMNS - 1));
        sts.replay_done = (ri_reg >= count_reg);
    end

    assign result = result_reg;

endmodule
`default_nettype wire

>>> sv/saa_ctrl.sv
`default_nettype none
module saa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic              out_ready,
    input  wire saa_pkg::saa_sts_t sts,
    output saa_pkg::saa_cmd_t      cmd,
    output logic [2:0]             err_status,
    output logic                   err_valid,
    output logic                   busy,
    output logic                   out_valid
);
    import saa_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_RAISE, S_CLEAR,
        S_FETCH, S_WAIT, S_SET, S_REPLAY, S_DONE, S_OUT
    } state_t;

    state_t     state_reg;
    logic [2:0] err_reg;
    logic       errv_reg;

    assign err_status = err_reg;
    assign err_valid  = errv_reg;
    assign busy       = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT);

    // command decode
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_INIT:   cmd.clear_step = 1'b1;
            S_IDLE:   cmd.load = in_fire;
            S_CHECK:  cmd.scan_init = 1'b1;
            S_SCAN:   cmd.scan_step = !sts.scan_done;
            S_DECIDE: cmd.commit = sts.found;
            S_RAISE:  cmd.raise_step = 1'b1;
            S_CLEAR:  cmd.clear_step = 1'b1;
            S_FETCH:  cmd.set_count = 1'b1;
            S_WAIT:   cmd.fetch = 1'b1;
            S_SET:    cmd.replay_set = 1'b1;
            S_REPLAY: cmd.raise_step = 1'b1;
            S_DONE:   cmd.finish = 1'b1;
            S_OUT:    cmd.finish = 1'b0;
            default:  cmd = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            err_reg   <= ST_OK;
            errv_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                // skyline clearing pass after reset
                S_INIT:
                begin
                    if (sts.clear_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    errv_reg <= 1'b0;
                    if (in_fire)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (sts.is_trunc)
                    begin
                        if (sts.bad_keep)
                        begin
                            err_reg <= ST_BAD_KEEP; errv_reg <= 1'b1; state_reg <= S_DONE;
                        end
                        else if (sts.keep_same)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_CLEAR;
                        end
                    end
                    else if (sts.full)
                    begin
                        err_reg <= ST_FULL; errv_reg <= 1'b1; state_reg <= S_DONE;
                    end
                    else if (sts.too_large)
                    begin
                        err_reg <= ST_TOO_LARGE; errv_reg <= 1'b1; state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (sts.found)
                    begin
                        state_reg <= S_RAISE;
                    end
                    else
                    begin
                        err_reg <= ST_NO_SPACE; errv_reg <= 1'b1; state_reg <= S_DONE;
                    end
                end
                S_RAISE:
                begin
                    if (sts.raise_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_CLEAR:
                begin
                    if (sts.clear_done)
                    begin
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:   state_reg <= S_WAIT;
                S_WAIT:
                begin
                    state_reg <= sts.replay_done ? S_DONE : S_SET;
                end
                S_SET:     state_reg <= S_REPLAY;
                S_REPLAY:
                begin
                    if (sts.raise_done)
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_DONE:    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/saa_checker.sv
`default_nettype none
module saa_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire saa_pkg::saa_out_t out_data
);
    import saa_pkg::*;

    // result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // no new item while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken with result pending");

    // busy right after an input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a beat");

    // errors carry zero payload (handle and cell_x checked)
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.handle == '0 && out_data.cell_x == '0)
        else $error("error result with payload");

    // status code in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ST_BAD_KEEP)
        else $error("bad status code");

endmodule

bind skyline_atlas_allocator_core saa_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
